// ----- rtl/ycr216_pkg.sv -----
package ycr216_pkg;

    // Fixed-point gains, 16 fractional bits
    localparam logic signed [27:0] CR_TO_R    = 28'sd104597;
    localparam logic signed [27:0] CB_TO_G    = 28'sd25674;
    localparam logic signed [27:0] CR_TO_G    = 28'sd53278;
    localparam logic signed [27:0] CB_TO_B    = 28'sd132201;
    localparam logic signed [27:0] LUMA_GAIN  = 28'sd76309;
    localparam logic signed [8:0]  CHROMA_MID = 9'sd128;
    localparam logic signed [8:0]  LUMA_BLACK = 9'sd16;
    localparam logic signed [10:0] CHAN_MAX   = 11'sd255;
    localparam logic [7:0]         R_WEIGHT   = 8'd36;
    localparam logic [7:0]         G_WEIGHT   = 8'd6;

    // x*5/255 steps up at every multiple of 51
    localparam logic [7:0] QUANT_STEP = 8'd51;

    typedef struct packed {
        logic [7:0] luma_top_left;
        logic [7:0] luma_top_right;
        logic [7:0] luma_bottom_left;
        logic [7:0] luma_bottom_right;
        logic [7:0] chroma_blue;
        logic [7:0] chroma_red;
    } t_in_word;

    typedef struct packed {
        logic [7:0] index_top_left;
        logic [7:0] index_top_right;
        logic [7:0] index_bottom_left;
        logic [7:0] index_bottom_right;
    } t_out_word;

    // Chroma offsets after the floor shift, shared by the four pixels
    typedef struct packed {
        logic signed [9:0] rd;
        logic signed [9:0] gd;
        logic signed [9:0] bd;
    } t_chroma;

    // Scaled luma term: floor(((y - 16) * 76309) / 65536), range -19..278
    function automatic logic signed [9:0] luma_term(input logic [7:0] y);
        logic signed [8:0]  y_off;
        logic signed [27:0] prod;
        begin
            y_off = $signed({1'b0, y}) - LUMA_BLACK;
            prod  = 28'(y_off) * LUMA_GAIN;
            return prod[25:16];
        end
    endfunction

endpackage

// ----- rtl/ycr216_chroma.sv -----
module ycr216_chroma
    import ycr216_pkg::*;
(
    input  logic [7:0] i_cb,
    input  logic [7:0] i_cr,
    output t_chroma    o_chroma
);

    logic signed [8:0]  cb;
    logic signed [8:0]  cr;
    logic signed [27:0] prod_r;
    logic signed [27:0] prod_g;
    logic signed [27:0] prod_b;

    always_comb begin
        cb     = $signed({1'b0, i_cb}) - CHROMA_MID;
        cr     = $signed({1'b0, i_cr}) - CHROMA_MID;
        prod_r = 28'(cr) * CR_TO_R;
        prod_g = 28'(cb) * CB_TO_G + 28'(cr) * CR_TO_G;
        prod_b = 28'(cb) * CB_TO_B;
        // Bits 25:16 are the arithmetic shift by 16; the values fit 10 bits
        o_chroma.rd = prod_r[25:16];
        o_chroma.gd = prod_g[25:16];
        o_chroma.bd = prod_b[25:16];
    end

endmodule

// ----- rtl/ycr216_pixel.sv -----
module ycr216_pixel
    import ycr216_pkg::*;
(
    input  logic signed [9:0] i_luma,
    input  t_chroma           i_chroma,
    output logic [7:0]        o_index
);

    function automatic logic [7:0] clamp_chan(input logic signed [10:0] v);
        begin
            if (v < 11'sd0) begin
                return 8'd0;
            end else if (v > CHAN_MAX) begin
                return 8'd255;
            end
            return v[7:0];
        end
    endfunction

    function automatic logic [7:0] quant(input logic [7:0] x);
        logic [7:0] q;
        begin
            q = 8'd0;
            if (x >= QUANT_STEP)        q = 8'd1;
            if (x >= 8'(QUANT_STEP * 2)) q = 8'd2;
            if (x >= 8'(QUANT_STEP * 3)) q = 8'd3;
            if (x >= 8'(QUANT_STEP * 4)) q = 8'd4;
            if (x >= 8'(QUANT_STEP * 5)) q = 8'd5;
            return q;
        end
    endfunction

    logic signed [10:0] sum_r;
    logic signed [10:0] sum_g;
    logic signed [10:0] sum_b;
    logic [7:0]         lvl_r;
    logic [7:0]         lvl_g;
    logic [7:0]         lvl_b;

    always_comb begin
        sum_r   = 11'(i_luma) + 11'(i_chroma.rd);
        sum_g   = 11'(i_luma) - 11'(i_chroma.gd);
        sum_b   = 11'(i_luma) + 11'(i_chroma.bd);
        lvl_r   = quant(clamp_chan(sum_r));
        lvl_g   = quant(clamp_chan(sum_g));
        lvl_b   = quant(clamp_chan(sum_b));
        o_index = lvl_r * R_WEIGHT + lvl_g * G_WEIGHT + lvl_b;
    end

endmodule

// ----- rtl/ycbcr420_to_rgb216_index_unit.sv -----
// Channel   Handshake            Payload     Direction
// input     start, busy          i_word      one 2x2 block: four luma, shared Cb/Cr
// result    o_strobe             o_word      four 6x6x6 palette indices
//
// Takes one word in every cycle; busy stays low. A result is held on o_word
// for exactly one cycle with o_strobe high. The depth is set by the input
// register, the product register after the constant multipliers, and the
// result register.
// Synchronous active-low reset clears the valid bits only; payload registers
// are left as they are. The receiver cannot stall, so nothing ever backs up.
module ycbcr420_to_rgb216_index_unit
    import ycr216_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_word  i_word,
    output logic      o_strobe,
    output t_out_word o_word
);

    // Input register
    logic     r_in_vld;
    t_in_word r_in;

    // Product register: chroma terms and four scaled luma terms
    logic              r_mid_vld;
    t_chroma           r_chroma;
    logic signed [9:0] r_luma [4];

    // Result register
    logic      r_out_vld;
    t_out_word r_out;

    t_chroma           n_chroma;
    logic signed [9:0] n_luma [4];
    logic [7:0]        n_index [4];

    // Never back-pressure: every stage advances each cycle
    assign busy = 1'b0;

    ycr216_chroma u_chroma (
        .i_cb     (r_in.chroma_blue),
        .i_cr     (r_in.chroma_red),
        .o_chroma (n_chroma)
    );

    always_comb begin
        n_luma[0] = luma_term(r_in.luma_top_left);
        n_luma[1] = luma_term(r_in.luma_top_right);
        n_luma[2] = luma_term(r_in.luma_bottom_left);
        n_luma[3] = luma_term(r_in.luma_bottom_right);
    end

    // One pixel path per luma sample, all sharing the registered chroma terms
    for (genvar g = 0; g < 4; g++) begin : g_pix
        ycr216_pixel u_pixel (
            .i_luma   (r_luma[g]),
            .i_chroma (r_chroma),
            .o_index  (n_index[g])
        );
    end

    // Valid bits: advance one stage per cycle, drop on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_mid_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= start && !busy;
            r_mid_vld <= r_in_vld;
            r_out_vld <= r_mid_vld;
        end
    end

    // Payload: the input register loads only on an accepted start; the others load unconditionally
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_in <= i_word;
        end
        r_chroma <= n_chroma;
        for (int k = 0; k < 4; k++) begin
            r_luma[k] <= n_luma[k];
        end
        r_out.index_top_left     <= n_index[0];
        r_out.index_top_right    <= n_index[1];
        r_out.index_bottom_left  <= n_index[2];
        r_out.index_bottom_right <= n_index[3];
    end

    assign o_strobe = r_out_vld;
    assign o_word   = r_out;

endmodule
